### src/lpa_pkg.sv
// lpa_pkg: shared constants, register indexes and status codes for the
// LoRa packet airtime core. No dependencies.
package lpa_pkg;

  localparam int unsigned MAX_PAYLOAD = 255;
  localparam int unsigned US_PER_S    = 1000000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // block-count divider: numerator up to 2139, denominator up to 60
  localparam int unsigned BLK_DW = 12;
  localparam int unsigned BLK_RW = 6;
  // airtime divider: quarters * 2^SF * 1e6 over 4 * bandwidth
  localparam int unsigned AIR_DW = 51;
  localparam int unsigned AIR_RW = 26;

  localparam int unsigned QTR_W  = 19;
  localparam int unsigned PROD_W = 39;
  localparam int unsigned SYMS_W = 11;

  // two math stages and the output register
  localparam int unsigned LATENCY = BLK_DW + AIR_DW + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BANDWIDTH = 3'd0,
    REG_PREAMBLE  = 3'd1,
    REG_SF        = 3'd2,
    REG_CR        = 3'd3,
    REG_LDRO      = 3'd4,
    REG_CRC       = 3'd5,
    REG_EXPLICIT  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CFG   = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } lane_ctl_t;

endpackage

### src/lpa_div_cell.sv
// lpa_div_cell: one restoring-division step, one quotient bit per cell.
// Uses lpa_pkg for the control struct.
module lpa_div_cell #(
  parameter int unsigned DW = 12,
  parameter int unsigned RW = 6,
  parameter int unsigned SW = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  lpa_pkg::lane_ctl_t in_ctl,
  input  logic [RW-1:0]      in_rem,
  input  logic [DW-1:0]      in_dq,
  input  logic [RW-1:0]      in_div,
  input  logic [SW-1:0]      in_side,
  output lpa_pkg::lane_ctl_t out_ctl,
  output logic [RW-1:0]      out_rem,
  output logic [DW-1:0]      out_dq,
  output logic [RW-1:0]      out_div,
  output logic [SW-1:0]      out_side
);

  logic [RW:0]   trial;
  logic          ge;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_next;

  always_comb begin
    trial    = {in_rem, in_dq[DW-1]};
    ge       = trial >= {1'b0, in_div};
    diff     = trial - {1'b0, in_div};
    rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
    out_ctl.status <= in_ctl.status;
    out_rem        <= rem_next;
    out_dq         <= {in_dq[DW-2:0], ge};
    out_div        <= in_div;
    out_side       <= in_side;
  end

endmodule

### src/lpa_div_chain.sv
// lpa_div_chain: a row of DW division cells, one quotient bit per cycle.
// Depends on lpa_pkg and lpa_div_cell.
module lpa_div_chain #(
  parameter int unsigned DW = 12,
  parameter int unsigned RW = 6,
  parameter int unsigned SW = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  lpa_pkg::lane_ctl_t in_ctl,
  input  logic [DW-1:0]      dividend,
  input  logic [RW-1:0]      divisor,
  input  logic [SW-1:0]      in_side,
  output lpa_pkg::lane_ctl_t out_ctl,
  output logic [DW-1:0]      quotient,
  output logic [RW-1:0]      remainder,
  output logic [SW-1:0]      out_side
);

  lpa_pkg::lane_ctl_t ctl  [DW+1];
  logic [RW-1:0]      rem  [DW+1];
  logic [DW-1:0]      dq   [DW+1];
  logic [RW-1:0]      div  [DW+1];
  logic [SW-1:0]      side [DW+1];

  assign ctl[0]  = in_ctl;
  assign rem[0]  = '0;
  assign dq[0]   = dividend;
  assign div[0]  = divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    lpa_div_cell #(.DW(DW), .RW(RW), .SW(SW)) u_cell (
      .clk, .rst,
      .in_ctl(ctl[i]), .in_rem(rem[i]), .in_dq(dq[i]), .in_div(div[i]),
      .in_side(side[i]),
      .out_ctl(ctl[i+1]), .out_rem(rem[i+1]), .out_dq(dq[i+1]),
      .out_div(div[i+1]), .out_side(side[i+1])
    );
  end

  assign out_ctl   = ctl[DW];
  assign quotient  = dq[DW];
  assign remainder = rem[DW];
  assign out_side  = side[DW];

endmodule

### src/lora_packet_airtime_core.sv
// lora_packet_airtime_core: LoRa payload symbol count and packet airtime.
// Depends on lpa_pkg and lpa_div_chain.
//
// Issue a payload length with start whenever busy is low (busy is high
// only during reset); one length can be taken every cycle. Each transfer
// returns exactly one result, shown for one cycle with done high. The
// latency is set by the two division cell rows: 12
// cells for the block count and 51 cells for the airtime, one quotient bit
// per cell, plus three register stages. The receiver cannot stall, so take
// every result in the cycle done is high. Write configuration only while no
// transfer is in flight; register indexes follow lpa_pkg::reg_idx_t and
// writes to index 7 are dropped. status 1 flags invalid settings and
// status 2 a payload over 255 bytes; both report zero airtime and symbols.
module lora_packet_airtime_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       payload_len,
  input  logic                              cfg_we,
  input  logic [lpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [47:0]                       airtime_us,
  output logic [lpa_pkg::SYMS_W-1:0]        payload_syms
);

  localparam int unsigned BDW = lpa_pkg::BLK_DW;
  localparam int unsigned BRW = lpa_pkg::BLK_RW;
  localparam int unsigned ADW = lpa_pkg::AIR_DW;
  localparam int unsigned ARW = lpa_pkg::AIR_RW;
  localparam int unsigned SYW = lpa_pkg::SYMS_W;
  localparam int unsigned QW  = lpa_pkg::QTR_W;
  localparam int unsigned PW  = lpa_pkg::PROD_W;

  // configuration registers
  logic [23:0] chan_bw;
  logic [15:0] preamble_len;
  logic [3:0]  sf;
  logic [3:0]  coding_rate_denom;
  logic        low_rate_optimize;
  logic        crc_enabled;
  logic        explicit_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_bw           <= 24'd125000;
      preamble_len      <= 16'd8;
      sf                <= 4'd7;
      coding_rate_denom <= 4'd5;
      low_rate_optimize <= 1'b0;
      crc_enabled       <= 1'b1;
      explicit_hdr      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpa_pkg::REG_BANDWIDTH: chan_bw           <= cfg_data;
        lpa_pkg::REG_PREAMBLE:  preamble_len      <= cfg_data[15:0];
        lpa_pkg::REG_SF:        sf                <= cfg_data[3:0];
        lpa_pkg::REG_CR:        coding_rate_denom <= cfg_data[3:0];
        lpa_pkg::REG_LDRO:      low_rate_optimize <= cfg_data[0];
        lpa_pkg::REG_CRC:       crc_enabled       <= cfg_data[0];
        lpa_pkg::REG_EXPLICIT:  explicit_hdr      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // front end: classify the transfer and form the block-count division
  lpa_pkg::lane_ctl_t front_ctl;
  logic               cfg_bad;
  logic [12:0]        num;
  logic [BRW-1:0]     den;
  logic [3:0]         sf_eff;
  logic [12:0]        num_round;
  logic [BDW-1:0]     nump;

  always_comb begin
    cfg_bad = (chan_bw == '0) || (preamble_len == '0) ||
              (sf < 4'd5) || (sf > 4'd12) ||
              (coding_rate_denom < 4'd5) || (coding_rate_denom > 4'd8);
    front_ctl.valid = start && !busy;
    priority if (cfg_bad) begin
      front_ctl.status = lpa_pkg::ST_BAD_CFG;
    end else if (payload_len > 16'(lpa_pkg::MAX_PAYLOAD)) begin
      front_ctl.status = lpa_pkg::ST_TOO_LARGE;
    end else begin
      front_ctl.status = lpa_pkg::ST_OK;
    end
    sf_eff = sf - (low_rate_optimize ? 4'd2 : 4'd0);
    den    = {sf_eff, 2'b00};
    // modular 13-bit arithmetic; bit 12 marks a negative numerator
    num = {2'b00, payload_len[7:0], 3'b000} + 13'd28
        + (crc_enabled ? 13'd16 : 13'd0)
        - (explicit_hdr ? 13'd0 : 13'd20)
        - {7'd0, sf, 2'b00};
    num_round = num + 13'(den) - 13'd1;
    nump = (!num[12] && num != '0) ? num_round[BDW-1:0] : '0;
  end

  lpa_pkg::lane_ctl_t blk_ctl;
  logic [BDW-1:0]     blk_q;
  logic [BRW-1:0]     blk_r;
  logic [1:0]         blk_side;

  lpa_div_chain #(.DW(BDW), .RW(BRW), .SW(2)) u_blk_div (
    .clk, .rst,
    .in_ctl(front_ctl), .dividend(nump), .divisor(den), .in_side(2'b00),
    .out_ctl(blk_ctl), .quotient(blk_q), .remainder(blk_r), .out_side(blk_side)
  );

  // stage A: symbol count and quarter-symbol total
  lpa_pkg::lane_ctl_t a_ctl;
  logic [SYW-1:0]     a_syms;
  logic [QW-1:0]      a_qtr;
  logic [SYW-1:0]     syms_next;
  logic [QW-1:0]      qtr_next;
  logic [15:0]        syms_wide;

  always_comb begin
    syms_wide = 16'(blk_q) * 16'(coding_rate_denom) + 16'd8;
    syms_next = syms_wide[SYW-1:0];
    qtr_next  = QW'({preamble_len, 2'b00}) + QW'(17) + QW'({syms_next, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.valid <= 1'b0;
    end else begin
      a_ctl.valid <= blk_ctl.valid;
    end
    a_ctl.status <= blk_ctl.status;
    a_syms       <= syms_next;
    a_qtr        <= qtr_next;
  end

  // stage B: scale to microseconds
  lpa_pkg::lane_ctl_t b_ctl;
  logic [SYW-1:0]     b_syms;
  logic [PW-1:0]      b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl.valid <= 1'b0;
    end else begin
      b_ctl.valid <= a_ctl.valid;
    end
    b_ctl.status <= a_ctl.status;
    b_syms       <= a_syms;
    b_prod       <= PW'(a_qtr) * PW'(lpa_pkg::US_PER_S);
  end

  // airtime division: quarters * 1e6 * 2^SF over 4 * bandwidth
  logic [ADW-1:0] air_num;
  logic [ARW-1:0] air_den;

  assign air_num = ADW'(b_prod) << sf;
  assign air_den = {chan_bw, 2'b00};

  lpa_pkg::lane_ctl_t air_ctl;
  logic [ADW-1:0]     air_q;
  logic [ARW-1:0]     air_r;
  logic [SYW-1:0]     air_syms;

  lpa_div_chain #(.DW(ADW), .RW(ARW), .SW(SYW)) u_air_div (
    .clk, .rst,
    .in_ctl(b_ctl), .dividend(air_num), .divisor(air_den), .in_side(b_syms),
    .out_ctl(air_ctl), .quotient(air_q), .remainder(air_r), .out_side(air_syms)
  );

  // output register: round up, zero airtime and symbols on error
  logic [ADW-1:0] air_ceil;
  logic           ok;

  always_comb begin
    air_ceil = air_q + ADW'(air_r != '0);
    ok       = air_ctl.status == lpa_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= air_ctl.valid;
    end
    status       <= air_ctl.status;
    airtime_us   <= ok ? air_ceil[47:0] : '0;
    payload_syms <= ok ? air_syms : '0;
  end

endmodule

### src/lpa_checker.sv
// lpa_checker: port-level checks for lora_packet_airtime_core, with bind.
// Depends on lpa_pkg.
module lpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [47:0] airtime_us,
  input logic [10:0] payload_syms
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(lpa_pkg::LATENCY) done)
    else $error("result missing after accepted transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lpa_pkg::LATENCY))
    else $error("result without matching transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != lpa_pkg::ST_OK) |-> (airtime_us == '0 && payload_syms == '0))
    else $error("error result carries nonzero fields");

  a_ok_syms: assert property (@(posedge clk) disable iff (rst)
    (done && status == lpa_pkg::ST_OK) |-> (payload_syms >= 11'd8 && airtime_us != '0))
    else $error("ok result below base symbol count");

endmodule

bind lora_packet_airtime_core lpa_checker u_lpa_checker (
  .clk, .rst, .start, .busy, .done, .status, .airtime_us, .payload_syms
);

### test/lora_packet_airtime_core_test.sv
// Self-checking testbench for lora_packet_airtime_core: a queue-fed driver
// and a strobe monitor, with an airtime predictor kept in step with config.
// Depends on lpa_pkg and the core RTL.
`timescale 1ns / 100ps

module lora_packet_airtime_core_test;

  typedef struct {
    logic [1:0]  status;
    logic [47:0] airtime;
    logic [10:0] syms;
  } airtime_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] payload_len = '0;
  logic cfg_we = 1'b0;
  logic [lpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [47:0] airtime_us;
  logic [lpa_pkg::SYMS_W-1:0] payload_syms;

  // predictor copy of the register file
  logic [23:0] bw_hz;
  logic [15:0] preamble;
  logic [3:0]  sf;
  logic [3:0]  cr;
  logic        ldro, crc_on, expl;

  logic [15:0] pending_lens[$];
  airtime_t    expected_air[$];
  logic [15:0] directed_lens[7];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;

  lora_packet_airtime_core dut (.*);

  always #1 clk = ~clk;

  // Compute status, symbol count and airtime for one payload length.
  function automatic airtime_t predict_airtime(input logic [15:0] len);
    airtime_t r;
    int num, den;
    longint unsigned syms, qtr, prod, div;
    r = '{lpa_pkg::ST_OK, '0, '0};
    if (bw_hz == 0 || preamble == 0 || sf < 5 || sf > 12 || cr < 5 || cr > 8) begin
      r.status = lpa_pkg::ST_BAD_CFG;
      return r;
    end
    if (len > lpa_pkg::MAX_PAYLOAD) begin
      r.status = lpa_pkg::ST_TOO_LARGE;
      return r;
    end
    den = 4 * (int'(sf) - (ldro ? 2 : 0));
    num = 8 * int'(len) - 4 * int'(sf) + 28 + (crc_on ? 16 : 0) - (expl ? 0 : 20);
    syms = 8;
    // nonpositive numerator: no payload blocks
    if (num > 0) syms += longint'((num + den - 1) / den) * cr;
    qtr = 4 * longint'(preamble) + 17 + 4 * syms;
    prod = (qtr << sf) * 64'd1000000;
    div = 4 * longint'(bw_hz);
    r.airtime = 48'(prod / div + ((prod % div) != 0));
    r.syms = 11'(syms);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Write a register at a clock edge and mirror it in the predictor.
  task automatic write_reg(input lpa_pkg::reg_idx_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lpa_pkg::REG_BANDWIDTH: bw_hz = val;
      lpa_pkg::REG_PREAMBLE:  preamble = val[15:0];
      lpa_pkg::REG_SF:        sf = val[3:0];
      lpa_pkg::REG_CR:        cr = val[3:0];
      lpa_pkg::REG_LDRO:      ldro = val[0];
      lpa_pkg::REG_CRC:       crc_on = val[0];
      lpa_pkg::REG_EXPLICIT:  expl = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_lens.size() == 0 && expected_air.size() == 0);
    repeat (lpa_pkg::LATENCY + 5) @(posedge clk);
  endtask

  // Driver: drive start while lengths are queued, idling at random by send_idle_pct; advance on each transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_air.push_back(predict_airtime(payload_len));
        void'(pending_lens.pop_front());
      end
      if (pending_lens.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        payload_len <= pending_lens[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    airtime_t e;
    cycles++;
    if (!rst && done) begin
      if (expected_air.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        e = expected_air.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (airtime_us !== e.airtime) report_mismatch("airtime_us", airtime_us, e.airtime);
        if (payload_syms !== e.syms) report_mismatch("payload_syms", payload_syms, e.syms);
      end
    end
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Push n random lengths; the driver pops each when its transfer happens.
  // Queue entry zero is the one on the port, so push only behind it.
  task automatic run_lens(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: pending_lens.push_back(16'($urandom));
        1: pending_lens.push_back(16'($urandom_range(256, 300)));
        2: pending_lens.push_back(16'($urandom_range(0, 4)));
        default: pending_lens.push_back(16'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic random_cfg();
    write_reg(lpa_pkg::REG_BANDWIDTH, $urandom_range(9) == 0 ? 24'($urandom) :
              24'($urandom_range(7800, 500000)));
    write_reg(lpa_pkg::REG_PREAMBLE, $urandom_range(9) == 0 ?
              24'($urandom_range(0, 65535)) : 24'($urandom_range(1, 20)));
    write_reg(lpa_pkg::REG_SF, $urandom_range(9) == 0 ? 24'($urandom_range(0, 15)) :
              24'($urandom_range(5, 12)));
    write_reg(lpa_pkg::REG_CR, $urandom_range(9) == 0 ? 24'($urandom_range(0, 15)) :
              24'($urandom_range(5, 8)));
    write_reg(lpa_pkg::REG_LDRO, 24'($urandom_range(1)));
    write_reg(lpa_pkg::REG_CRC, 24'($urandom_range(1)));
    write_reg(lpa_pkg::REG_EXPLICIT, 24'($urandom_range(1)));
  endtask

  initial begin
    int ph;
    bw_hz = 24'd125000; preamble = 16'd8; sf = 4'd7; cr = 4'd5;
    ldro = 1'b0; crc_on = 1'b1; expl = 1'b1;
    directed_lens = '{16'd0, 16'd1, 16'd255, 16'd256, 16'hFFFF, 16'h5555, 16'hAAAA};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (!busy);
    // directed: reset settings, field extremes, too-large boundary
    foreach (directed_lens[k])
      pending_lens.push_back(directed_lens[k]);
    wait_drained();
    // extremes of settings: largest SF with optimization and implicit header,
    // smallest SF, then every invalid-setting cause
    write_reg(lpa_pkg::REG_SF, 24'd12); write_reg(lpa_pkg::REG_LDRO, 24'd1);
    write_reg(lpa_pkg::REG_CR, 24'd8);
    write_reg(lpa_pkg::REG_CRC, 24'd0); write_reg(lpa_pkg::REG_EXPLICIT, 24'd0);
    write_reg(lpa_pkg::REG_BANDWIDTH, 24'd1);
    write_reg(lpa_pkg::REG_PREAMBLE, 24'hFFFF);
    pending_lens.push_back(16'd0); pending_lens.push_back(16'd255);
    pending_lens.push_back(16'd8);
    wait_drained();
    write_reg(lpa_pkg::REG_SF, 24'd5); write_reg(lpa_pkg::REG_LDRO, 24'd0);
    write_reg(lpa_pkg::REG_BANDWIDTH, 24'hFFFFFF);
    write_reg(lpa_pkg::REG_PREAMBLE, 24'd1); write_reg(lpa_pkg::REG_CR, 24'd5);
    pending_lens.push_back(16'd0); pending_lens.push_back(16'd255);
    wait_drained();
    write_reg(lpa_pkg::REG_BANDWIDTH, 24'd0); pending_lens.push_back(16'd10);
    wait_drained();
    write_reg(lpa_pkg::REG_BANDWIDTH, 24'd125000);
    write_reg(lpa_pkg::REG_PREAMBLE, 24'd0);
    pending_lens.push_back(16'd10); wait_drained();
    write_reg(lpa_pkg::REG_PREAMBLE, 24'd8); write_reg(lpa_pkg::REG_SF, 24'd4);
    pending_lens.push_back(16'd10);
    wait_drained();
    write_reg(lpa_pkg::REG_SF, 24'd13); pending_lens.push_back(16'd300);
    wait_drained();
    write_reg(lpa_pkg::REG_SF, 24'd7); write_reg(lpa_pkg::REG_CR, 24'd9);
    pending_lens.push_back(16'd10);
    wait_drained();
    write_reg(lpa_pkg::REG_CR, 24'd4); pending_lens.push_back(16'd10);
    wait_drained();
    // random phases, sender idling 7, 80, then 0 percent
    for (ph = 0; ph < 24; ph++) begin
      send_idle_pct = ph < 8 ? 7 : (ph < 16 ? 80 : 0);
      random_cfg();
      run_lens(70);
      wait_drained();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
